### sv/cfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conveyor fault monitor package
// Shared types, register map and widths of the conveyor fault monitor.
// ----------------------------------------------------------------------------
package cfm_pkg;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_STALL_CURRENT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STALL_WINDOW  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STALL_GAIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY_CURRENT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY_HOLD    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OBST_CURRENT  = 3'd5;

  localparam logic [15:0]        STALL_WINDOW_RESET = 16'd2000;
  localparam logic signed [23:0] STALL_GAIN_RESET   = 24'sd100;
  localparam logic [15:0]        EMPTY_HOLD_RESET   = 16'd1000;

  typedef struct packed {
    logic [15:0]        stall_current_ma;
    logic [15:0]        stall_window_ms;
    logic signed [23:0] stall_mass_gain_g;
    logic [15:0]        empty_cut_current_ma;
    logic [15:0]        empty_cut_hold_ms;
    logic [15:0]        obstruct_current_ma;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               belt_active;
    logic               lowering;
    logic               stop_event;
    logic [15:0]        belt_current_ma;
    logic [15:0]        lift_current_ma;
    logic signed [23:0] mass_g;
  } sample_t;

  typedef struct packed {
    logic               stall_latch;
    logic               stall_timing;
    logic [31:0]        stall_start_time;
    logic signed [23:0] stall_start_mass;
    logic               empty_timing;
    logic [31:0]        empty_start_time;
  } state_t;

  typedef struct packed {
    logic stalled;
    logic empty_cut;
    logic obstructed;
  } flags_t;

endpackage

### sv/cfm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conveyor fault monitor registers
// APB-style register file holding the six detector thresholds and times.
// ----------------------------------------------------------------------------
module cfm_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cfm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cfm_pkg::cfg_t             cfg
);
  import cfm_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stall_current_ma     <= '0;
      cfg.stall_window_ms      <= STALL_WINDOW_RESET;
      cfg.stall_mass_gain_g    <= STALL_GAIN_RESET;
      cfg.empty_cut_current_ma <= '0;
      cfg.empty_cut_hold_ms    <= EMPTY_HOLD_RESET;
      cfg.obstruct_current_ma  <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_STALL_CURRENT: cfg.stall_current_ma     <= pwdata[15:0];
        REG_STALL_WINDOW:  cfg.stall_window_ms      <= pwdata[15:0];
        REG_STALL_GAIN:    cfg.stall_mass_gain_g    <= $signed(pwdata[23:0]);
        REG_EMPTY_CURRENT: cfg.empty_cut_current_ma <= pwdata[15:0];
        REG_EMPTY_HOLD:    cfg.empty_cut_hold_ms    <= pwdata[15:0];
        REG_OBST_CURRENT:  cfg.obstruct_current_ma  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STALL_CURRENT: prdata = {16'd0, cfg.stall_current_ma};
      REG_STALL_WINDOW:  prdata = {16'd0, cfg.stall_window_ms};
      REG_STALL_GAIN:    prdata = {{8{cfg.stall_mass_gain_g[23]}}, cfg.stall_mass_gain_g};
      REG_EMPTY_CURRENT: prdata = {16'd0, cfg.empty_cut_current_ma};
      REG_EMPTY_HOLD:    prdata = {16'd0, cfg.empty_cut_hold_ms};
      REG_OBST_CURRENT:  prdata = {16'd0, cfg.obstruct_current_ma};
      default:           prdata = '0;
    endcase
  end

endmodule

### sv/cfm_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conveyor fault monitor evaluation
// Combinational step: next detector state and the three flags for one sample.
// ----------------------------------------------------------------------------
module cfm_eval (
  input  cfm_pkg::cfg_t    cfg,
  input  cfm_pkg::sample_t smp,
  input  cfm_pkg::state_t  st,
  output cfm_pkg::state_t  st_next,
  output cfm_pkg::flags_t  flags
);
  import cfm_pkg::*;

  logic               latch_cur;
  logic [31:0]        stall_elapsed;
  logic [31:0]        empty_elapsed;
  logic [31:0]        empty_base;
  logic signed [24:0] gain;
  logic               gain_low;

  assign latch_cur     = st.stall_latch && !smp.stop_event && smp.belt_active;
  assign stall_elapsed = smp.now_ms - st.stall_start_time;
  assign gain          = {smp.mass_g[23], smp.mass_g} -
                         {st.stall_start_mass[23], st.stall_start_mass};
  assign gain_low      = gain < $signed({cfg.stall_mass_gain_g[23], cfg.stall_mass_gain_g});
  assign empty_base    = st.empty_timing ? st.empty_start_time : smp.now_ms;
  assign empty_elapsed = smp.now_ms - empty_base;

  always_comb begin
    st_next             = st;
    st_next.stall_latch = latch_cur;
    flags               = '0;

    if (cfg.stall_current_ma != 16'd0) begin
      priority if (!smp.belt_active) begin
        st_next.stall_timing = 1'b0;
      end else if (latch_cur) begin
        flags.stalled = 1'b1;
      end else if (smp.belt_current_ma < cfg.stall_current_ma) begin
        st_next.stall_timing = 1'b0;
      end else if (!st.stall_timing) begin
        st_next.stall_timing     = 1'b1;
        st_next.stall_start_time = smp.now_ms;
        st_next.stall_start_mass = smp.mass_g;
      end else begin
        if (stall_elapsed >= {16'd0, cfg.stall_window_ms}) begin
          if (gain_low) begin
            st_next.stall_latch = 1'b1;
            flags.stalled       = 1'b1;
          end else begin
            st_next.stall_start_time = smp.now_ms;
            st_next.stall_start_mass = smp.mass_g;
          end
        end
      end
    end

    if (cfg.empty_cut_current_ma != 16'd0) begin
      priority if (!smp.belt_active) begin
        st_next.empty_timing = 1'b0;
      end else if (smp.belt_current_ma < cfg.empty_cut_current_ma) begin
        st_next.empty_timing     = 1'b1;
        st_next.empty_start_time = empty_base;
        flags.empty_cut          = empty_elapsed >= {16'd0, cfg.empty_cut_hold_ms};
      end else begin
        st_next.empty_timing = 1'b0;
      end
    end

    flags.obstructed = (cfg.obstruct_current_ma != 16'd0) && smp.lowering &&
                       (smp.lift_current_ma > cfg.obstruct_current_ma);
  end

endmodule

### sv/conveyor_fault_monitor_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the result register is empty or being taken;
// input register, one evaluation pass, result register.
// The input side stalls only when the result register is full and not being taken.
// Reset (rst, synchronous, active high) empties both registers, clears all detector
// state and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Conveyor fault monitor core
// Checks belt stall, empty cut and lift obstruction for each sensor sample.
// ----------------------------------------------------------------------------
module conveyor_fault_monitor_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                now_ms,
  input  logic                       belt_active,
  input  logic                       lowering,
  input  logic                       stop_event,
  input  logic [15:0]                belt_current_ma,
  input  logic [15:0]                lift_current_ma,
  input  logic signed [23:0]         mass_g,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       stalled,
  output logic                       empty_cut,
  output logic                       obstructed
);
  import cfm_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  logic    smp_valid;
  logic    advance;
  state_t  st;
  state_t  st_next;
  flags_t  flags_next;
  flags_t  flags;

  cfm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = smp_valid && (!out_valid || out_ready);
  assign in_ready = !smp_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp.now_ms          <= now_ms;
      smp.belt_active     <= belt_active;
      smp.lowering        <= lowering;
      smp.stop_event      <= stop_event;
      smp.belt_current_ma <= belt_current_ma;
      smp.lift_current_ma <= lift_current_ma;
      smp.mass_g          <= mass_g;
    end
  end

  cfm_eval u_eval (
    .cfg     (cfg),
    .smp     (smp),
    .st      (st),
    .st_next (st_next),
    .flags   (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags <= flags_next;
    end
  end

  assign stalled    = flags.stalled;
  assign empty_cut  = flags.empty_cut;
  assign obstructed = flags.obstructed;

endmodule

### sv/cfm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conveyor fault monitor checker
// Port-level checks on the monitor core, attached by a bind statement.
// ----------------------------------------------------------------------------
module cfm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic belt_active,
  input logic lowering,
  input logic out_valid,
  input logic out_ready,
  input logic stalled,
  input logic empty_cut,
  input logic obstructed
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({stalled, empty_cut, obstructed}))
    else $error("Result beat changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("Result valid right after reset.");

  a_idle_belt: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !belt_active) ##1 out_ready |=>
      out_valid && !stalled && !empty_cut)
    else $error("Belt flags raised for a beat with the belt inactive.");

  a_no_lowering: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !lowering) ##1 out_ready |=> out_valid && !obstructed)
    else $error("Obstruction raised for a beat without lift descent.");

endmodule

bind conveyor_fault_monitor_core cfm_checker u_cfm_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conveyor fault monitor testbench
// Feeds sensor samples through the valid/ready input and checks every flag beat
// against a predictor kept inside the bench. A short directed sequence covers
// stall latching, stop events, window rollover, mass and timestamp extremes,
// empty-cut onset and obstruction thresholds. Random phases then run under
// several register settings and pacing modes, with APB writes only while idle.
// ----------------------------------------------------------------------------
module testbench;

  import cfm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         now_ms;
  logic                belt_active;
  logic                lowering;
  logic                stop_event;
  logic [15:0]         belt_current_ma;
  logic [15:0]         lift_current_ma;
  logic signed [23:0]  mass_g;
  logic                out_valid;
  logic                out_ready;
  logic                stalled;
  logic                empty_cut;
  logic                obstructed;

  cfg_t     det_cfg;
  state_t   det_state;
  sample_t  sample_queue[$];
  flags_t   expected_flags[$];

  int       send_idle_pct;
  int       recv_stall_pct;
  bit       in_taken;
  int       queued_count;
  int       checked_count;
  int       fail_count;
  int       cycle_count;
  int       settings_count;
  int       stall_seen;
  int       empty_seen;
  int       obstruct_seen;

  logic [31:0] sim_now;
  int          sim_mass;

  conveyor_fault_monitor_core uut (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .now_ms          (now_ms),
    .belt_active     (belt_active),
    .lowering        (lowering),
    .stop_event      (stop_event),
    .belt_current_ma (belt_current_ma),
    .lift_current_ma (lift_current_ma),
    .mass_g          (mass_g),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .stalled         (stalled),
    .empty_cut       (empty_cut),
    .obstructed      (obstructed)
  );

  always #5 clk = ~clk;

  function automatic flags_t predict_flags(sample_t s);
    flags_t      f;
    logic [31:0] elapsed;
    int          cur_mass;
    int          start_mass;
    int          min_gain;
    f = '0;
    cur_mass   = {{8{s.mass_g[23]}}, s.mass_g};
    start_mass = {{8{det_state.stall_start_mass[23]}}, det_state.stall_start_mass};
    min_gain   = {{8{det_cfg.stall_mass_gain_g[23]}}, det_cfg.stall_mass_gain_g};
    if (s.stop_event || !s.belt_active) begin
      det_state.stall_latch = 1'b0;
    end
    if (det_cfg.stall_current_ma != 16'd0) begin
      if (!s.belt_active) begin
        det_state.stall_timing = 1'b0;
      end else if (det_state.stall_latch) begin
        f.stalled = 1'b1;
      end else if (s.belt_current_ma < det_cfg.stall_current_ma) begin
        det_state.stall_timing = 1'b0;
      end else if (!det_state.stall_timing) begin
        det_state.stall_timing     = 1'b1;
        det_state.stall_start_time = s.now_ms;
        det_state.stall_start_mass = s.mass_g;
      end else begin
        elapsed = s.now_ms - det_state.stall_start_time;
        if (elapsed >= {16'd0, det_cfg.stall_window_ms}) begin
          if (cur_mass - start_mass < min_gain) begin
            det_state.stall_latch = 1'b1;
            f.stalled = 1'b1;
          end else begin
            det_state.stall_start_time = s.now_ms;
            det_state.stall_start_mass = s.mass_g;
          end
        end
      end
    end
    if (det_cfg.empty_cut_current_ma != 16'd0) begin
      if (!s.belt_active) begin
        det_state.empty_timing = 1'b0;
      end else if (s.belt_current_ma < det_cfg.empty_cut_current_ma) begin
        if (!det_state.empty_timing) begin
          det_state.empty_timing     = 1'b1;
          det_state.empty_start_time = s.now_ms;
        end
        elapsed = s.now_ms - det_state.empty_start_time;
        if (elapsed >= {16'd0, det_cfg.empty_cut_hold_ms}) begin
          f.empty_cut = 1'b1;
        end
      end else begin
        det_state.empty_timing = 1'b0;
      end
    end
    if (det_cfg.obstruct_current_ma != 16'd0 && s.lowering &&
        s.lift_current_ma > det_cfg.obstruct_current_ma) begin
      f.obstructed = 1'b1;
    end
    return f;
  endfunction

  function automatic cfg_t make_cfg(int sc, int sw, int sg, int ec, int eh, int oc);
    cfg_t c;
    c.stall_current_ma     = sc[15:0];
    c.stall_window_ms      = sw[15:0];
    c.stall_mass_gain_g    = sg[23:0];
    c.empty_cut_current_ma = ec[15:0];
    c.empty_cut_hold_ms    = eh[15:0];
    c.obstruct_current_ma  = oc[15:0];
    return c;
  endfunction

  function automatic logic [15:0] clamp_current(int v);
    if (v < 0) begin
      return 16'd0;
    end else if (v > 65535) begin
      return 16'hFFFF;
    end
    return v[15:0];
  endfunction

  task automatic push_sample(logic [31:0] t, bit belt, bit low, bit stop,
                             int bc, int lc, int m);
    sample_t s;
    s.now_ms          = t;
    s.belt_active     = belt;
    s.lowering        = low;
    s.stop_event      = stop;
    s.belt_current_ma = clamp_current(bc);
    s.lift_current_ma = clamp_current(lc);
    s.mass_g          = m[23:0];
    sample_queue.push_back(s);
    queued_count++;
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STALL_CURRENT: det_cfg.stall_current_ma     = data[15:0];
      REG_STALL_WINDOW:  det_cfg.stall_window_ms      = data[15:0];
      REG_STALL_GAIN:    det_cfg.stall_mass_gain_g    = data[23:0];
      REG_EMPTY_CURRENT: det_cfg.empty_cut_current_ma = data[15:0];
      REG_EMPTY_HOLD:    det_cfg.empty_cut_hold_ms    = data[15:0];
      REG_OBST_CURRENT:  det_cfg.obstruct_current_ma  = data[15:0];
      default: ;
    endcase
  endtask

  task automatic load_config(cfg_t c);
    apb_write(REG_STALL_CURRENT, {16'd0, c.stall_current_ma});
    apb_write(REG_STALL_WINDOW,  {16'd0, c.stall_window_ms});
    apb_write(REG_STALL_GAIN,    {{8{c.stall_mass_gain_g[23]}}, c.stall_mass_gain_g});
    apb_write(REG_EMPTY_CURRENT, {16'd0, c.empty_cut_current_ma});
    apb_write(REG_EMPTY_HOLD,    {16'd0, c.empty_cut_hold_ms});
    apb_write(REG_OBST_CURRENT,  {16'd0, c.obstruct_current_ma});
    settings_count++;
  endtask

  task automatic set_pace(pace_t p);
    case (p)
      PACE_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_IDLE:  begin send_idle_pct = 69; recv_stall_pct = 0;  end
      PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 69; end
      default:         begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (checked_count != queued_count);
    repeat (4) @(negedge clk);
  endtask

  // Samples come in runs that hold one current regime and one mass trend, so
  // stall windows and empty-cut hold times actually get to close.
  task automatic gen_samples(int n, int step, int mscale);
    int  run_left;
    int  regime;
    int  mass_rate;
    int  bc;
    int  lc;
    int  base;
    int  r;
    bit  belt;
    bit  low;
    bit  stop;
    run_left  = 0;
    regime    = 0;
    mass_rate = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        regime    = (r < 40) ? 0 : (r < 60) ? 1 : (r < 88) ? 2 : 3;
        run_left  = $urandom_range(5, 40);
        mass_rate = int'($urandom_range(0, 2 * mscale)) - mscale / 4;
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 80) begin
        sim_now = sim_now + $urandom_range(0, step);
      end else if (r < 97) begin
        sim_now = sim_now + $urandom_range(0, 4 * step);
      end else begin
        sim_now = sim_now + $urandom;
      end
      if (regime == 3) begin
        push_sample($urandom, $urandom_range(0, 1), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom);
      end else begin
        case (regime)
          0: bc = int'(det_cfg.stall_current_ma) + int'($urandom_range(0, 300));
          1: begin
            if (det_cfg.empty_cut_current_ma == 16'd0) begin
              bc = $urandom_range(0, 50);
            end else begin
              bc = int'(det_cfg.empty_cut_current_ma) - 1 -
                   int'($urandom_range(0, det_cfg.empty_cut_current_ma / 2));
            end
          end
          default: begin
            base = $urandom_range(0, 1) ? int'(det_cfg.stall_current_ma)
                                        : int'(det_cfg.empty_cut_current_ma);
            bc = base + int'($urandom_range(0, 8)) - 4;
          end
        endcase
        if ($urandom_range(0, 1)) begin
          lc = int'(det_cfg.obstruct_current_ma) + int'($urandom_range(0, 4)) - 2;
        end else begin
          lc = $urandom_range(0, 65535);
        end
        belt = ($urandom_range(0, 99) < 96);
        stop = ($urandom_range(0, 99) < 3);
        low  = ($urandom_range(0, 99) < 60);
        r = $urandom_range(0, 199);
        if (r == 0) begin
          sim_mass = -8388608;
        end else if (r == 1) begin
          sim_mass = 8388607;
        end else begin
          sim_mass = sim_mass + mass_rate;
        end
        push_sample(sim_now, belt, low, stop, bc, lc, sim_mass);
      end
    end
  endtask

  always @(negedge clk) begin : sample_driver
    sample_t nxt;
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (in_valid && !in_taken) begin
      // Hold the beat until the block takes it.
    end else if (!rst && sample_queue.size() > 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      nxt = sample_queue.pop_front();
      in_valid        <= 1'b1;
      now_ms          <= nxt.now_ms;
      belt_active     <= nxt.belt_active;
      lowering        <= nxt.lowering;
      stop_event      <= nxt.stop_event;
      belt_current_ma <= nxt.belt_current_ma;
      lift_current_ma <= nxt.lift_current_ma;
      mass_g          <= nxt.mass_g;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin : flag_monitor
    sample_t s;
    flags_t  got;
    flags_t  want;
    in_taken = in_valid && in_ready && !rst;
    if (!rst) begin
      if (in_valid && in_ready) begin
        s.now_ms          = now_ms;
        s.belt_active     = belt_active;
        s.lowering        = lowering;
        s.stop_event      = stop_event;
        s.belt_current_ma = belt_current_ma;
        s.lift_current_ma = lift_current_ma;
        s.mass_g          = mass_g;
        expected_flags.push_back(predict_flags(s));
      end
      if (out_valid && out_ready) begin
        got.stalled    = stalled;
        got.empty_cut  = empty_cut;
        got.obstructed = obstructed;
        if (expected_flags.size() == 0) begin
          if (fail_count < 10) begin
            $display("Unexpected flag beat: stalled=%0b empty_cut=%0b obstructed=%0b",
                     got.stalled, got.empty_cut, got.obstructed);
          end
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("Mismatch on beat %0d: expected stalled=%0b empty_cut=%0b %s%0b",
                       checked_count, want.stalled, want.empty_cut, "obstructed=",
                       want.obstructed);
              $display("  got stalled=%0b empty_cut=%0b obstructed=%0b",
                       got.stalled, got.empty_cut, got.obstructed);
            end
            fail_count++;
          end
          stall_seen    += want.stalled;
          empty_seen    += want.empty_cut;
          obstruct_seen += want.obstructed;
          checked_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t phase_cfg[PHASES];
    int   phase_step[PHASES];
    int   phase_mass[PHASES];
    clk             = 1'b0;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    now_ms          = '0;
    belt_active     = 1'b0;
    lowering        = 1'b0;
    stop_event      = 1'b0;
    belt_current_ma = '0;
    lift_current_ma = '0;
    mass_g          = '0;
    out_ready       = 1'b0;
    in_taken        = 1'b0;
    queued_count    = 0;
    checked_count   = 0;
    fail_count      = 0;
    cycle_count     = 0;
    settings_count  = 1;
    stall_seen      = 0;
    empty_seen      = 0;
    obstruct_seen   = 0;
    sim_now         = 32'd0;
    sim_mass        = 0;
    det_cfg         = make_cfg(0, STALL_WINDOW_RESET, STALL_GAIN_RESET, 0,
                               EMPTY_HOLD_RESET, 0);
    det_state       = '0;
    set_pace(PACE_FREE);

    phase_cfg[0] = make_cfg(800, 200, 30, 300, 150, 2000);
    phase_cfg[1] = make_cfg(65535, 0, -8388608, 65535, 65535, 65535);
    phase_cfg[2] = make_cfg(1, 65535, 8388607, 1, 0, 1);
    phase_cfg[3] = make_cfg(3000, 500, 200, 1000, 300, 5000);
    phase_cfg[4] = make_cfg(500, 1, 0, 0, 200, 0);
    phase_cfg[5] = make_cfg(0, 100, 10, 700, 0, 300);
    phase_cfg[6] = make_cfg(1200, 2000, 100, 400, 1000, 1500);
    phase_cfg[7] = make_cfg(200, 50, -20, 200, 50, 800);
    phase_step   = '{40, 30, 20000, 100, 2, 50, 300, 15};
    phase_mass   = '{20, 1000, 5000, 60, 3, 10, 40, 10};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Writes outside the register map must leave the defaults alone.
    apb_write(REG_SPARE_LO, $urandom);
    apb_write(REG_SPARE_HI, $urandom);
    gen_samples(60, 50, 20);
    wait_drained();

    load_config(make_cfg(500, 100, 50, 200, 0, 1000));
    push_sample(32'd0,   1, 0, 0, 600, 0, 0);
    push_sample(32'd60,  1, 0, 0, 600, 0, 10);
    push_sample(32'd100, 1, 0, 0, 500, 0, 20);
    push_sample(32'd150, 1, 0, 0, 100, 0, 20);
    push_sample(32'd160, 1, 0, 1, 600, 0, 20);
    push_sample(32'd170, 0, 0, 0, 600, 0, 20);
    push_sample(32'd180, 1, 0, 0, 600, 0, -8388608);
    push_sample(32'd300, 1, 0, 0, 600, 0, 8388607);
    push_sample(32'd350, 1, 0, 0, 499, 0, 8388607);
    push_sample(32'hFFFF_FFC0, 1, 0, 0, 65535, 0, 0);
    push_sample(32'h0000_0030, 1, 0, 0, 65535, 0, 10);
    push_sample(32'h0000_0040, 1, 1, 0, 0, 1001, 0);
    push_sample(32'h0000_0050, 1, 1, 0, 0, 1000, 0);
    push_sample(32'h0000_0060, 1, 0, 0, 0, 65535, 0);
    push_sample(32'h0000_0070, 1, 1, 1, 65535, 65535, 0);
    push_sample(32'h0000_0080, 0, 1, 0, 0, 0, 0);
    wait_drained();

    load_config(make_cfg(65535, 0, 8388607, 65535, 65535, 65535));
    push_sample(32'd1000,  1, 0, 0, 65535, 65535, 0);
    push_sample(32'd1000,  1, 1, 0, 65535, 65535, 0);
    push_sample(32'd2000,  1, 0, 0, 65534, 0, 0);
    push_sample(32'd67535, 1, 0, 0, 0, 0, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      set_pace(pace_t'(p % 4));
      load_config(phase_cfg[p]);
      if (p == PHASES - 1) begin
        sim_now = 32'hFFFF_F000;
      end
      gen_samples(180, phase_step[p], phase_mass[p]);
      wait_drained();
    end

    repeat (10) @(negedge clk);
    fail_count += expected_flags.size();
    $display("Checked %0d flag beats over %0d register settings and four pacing modes.",
             checked_count, settings_count);
    $display("Expected flags raised: stall %0d, empty cut %0d, obstruction %0d.",
             stall_seen, empty_seen, obstruct_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/cfm_pkg.sv
sv/cfm_regs.sv
sv/cfm_eval.sv
sv/conveyor_fault_monitor_core.sv
sv/cfm_checker.sv
bench/testbench.sv
